// ===== design/mbsl_pkg.sv =====
`timescale 1ns / 1ps
package mbsl_pkg;

  localparam int GAIN_W = 16;
  localparam int PAN_W = 22;
  localparam int GAIN_FRAC = 14;
  localparam int PAN_FRAC = 22;
  localparam int SCALE_SHIFT = GAIN_FRAC + PAN_FRAC;

  // gain * pan product, split into two halves for the two multiply stages
  localparam int GP_W = GAIN_W + PAN_W;
  localparam int GP_LO_W = GP_W / 2;
  localparam int GP_HI_W = GP_W - GP_LO_W;

  localparam int THR_NUM = 891;
  localparam int THR_DEN = 1000;

  typedef logic [GAIN_W-1:0] gain_t;
  typedef logic [GP_W-1:0] gain_pan_t;

  localparam gain_t GAIN_RESET = 16'd16384;
  localparam logic [PAN_W-1:0] PAN_Q22 = 22'd2965821;

endpackage

// ===== design/mbsl_sum.sv =====
`timescale 1ns / 1ps
module mbsl_sum #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_ch1,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_ch2,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_ch3,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_ch4,
  input  logic                           frame_last_in,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic        [SAMPLE_WIDTH+1:0] mag,
  output logic                           neg,
  output logic                           last
);

  localparam int SUM_W = SAMPLE_WIDTH + 2;

  logic                    v1;
  logic signed [SUM_W-1:0] sum1;
  logic                    last1;
  logic                    v2;
  logic        [SUM_W-1:0] mag2;
  logic                    neg2;
  logic                    last2;
  logic                    busy1;
  logic                    busy2;

  assign busy2 = v2 && out_stall;
  assign busy1 = v1 && busy2;
  assign in_stall = busy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (!busy1) v1 <= in_valid;
      if (!busy2) v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (!busy1) begin
      sum1 <= SUM_W'(sample_ch1) + SUM_W'(sample_ch2) + SUM_W'(sample_ch3)
            + SUM_W'(sample_ch4);
      last1 <= frame_last_in;
    end
    if (!busy2) begin
      // two's complement negate keeps the most negative sum as its magnitude
      mag2  <= sum1[SUM_W-1] ? (~sum1 + SUM_W'(1)) : sum1;
      neg2  <= sum1[SUM_W-1];
      last2 <= last1;
    end
  end

  assign out_valid = v2;
  assign mag = mag2;
  assign neg = neg2;
  assign last = last2;

endmodule

// ===== design/mbsl_scale.sv =====
`timescale 1ns / 1ps
module mbsl_scale #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  mbsl_pkg::gain_t           cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [SAMPLE_WIDTH+1:0]   mag,
  input  logic                      neg,
  input  logic                      last,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [SAMPLE_WIDTH+3:0]   res,
  output logic                      res_neg,
  output logic                      res_last
);

  localparam int MAG_W = SAMPLE_WIDTH + 2;
  localparam int PP_W = MAG_W + mbsl_pkg::GP_HI_W;
  localparam int PW = MAG_W + mbsl_pkg::GP_W;
  localparam int RES_W = SAMPLE_WIDTH + 4;
  localparam logic [PW-1:0] RND = PW'(1) << (mbsl_pkg::SCALE_SHIFT - 1);
  localparam mbsl_pkg::gain_pan_t GP_RESET =
    mbsl_pkg::gain_pan_t'(mbsl_pkg::GAIN_RESET) * mbsl_pkg::gain_pan_t'(mbsl_pkg::PAN_Q22);

  mbsl_pkg::gain_t     gain;
  mbsl_pkg::gain_pan_t gp;

  logic             v3;
  logic [MAG_W-1:0] mag3;
  logic [PP_W-1:0]  plo3;
  logic             neg3;
  logic             last3;
  logic             v4;
  logic [PP_W-1:0]  plo4;
  logic [PP_W-1:0]  phi4;
  logic             neg4;
  logic             last4;
  logic             v5;
  logic [RES_W-1:0] res5;
  logic             neg5;
  logic             last5;
  logic             busy3;
  logic             busy4;
  logic             busy5;
  logic [PW-1:0]    prod;

  // gain*pan registered; user keeps items off multipliers until it settles, unenforced
  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= mbsl_pkg::GAIN_RESET;
      gp   <= GP_RESET;
    end else begin
      if (cfg_we) gain <= cfg_data;
      gp <= mbsl_pkg::gain_pan_t'(gain) * mbsl_pkg::gain_pan_t'(mbsl_pkg::PAN_Q22);
    end
  end

  assign busy5 = v5 && out_stall;
  assign busy4 = v4 && busy5;
  assign busy3 = v3 && busy4;
  assign in_stall = busy3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (!busy3) v3 <= in_valid;
      if (!busy4) v4 <= v3;
      if (!busy5) v5 <= v4;
    end
  end

  assign prod = (PW'(phi4) << mbsl_pkg::GP_LO_W) + PW'(plo4) + RND;

  always_ff @(posedge clk) begin
    if (!busy3) begin
      mag3  <= mag;
      plo3  <= PP_W'(mag) * PP_W'(gp[mbsl_pkg::GP_LO_W-1:0]);
      neg3  <= neg;
      last3 <= last;
    end
    if (!busy4) begin
      plo4  <= plo3;
      phi4  <= PP_W'(mag3) * PP_W'(gp[mbsl_pkg::GP_W-1:mbsl_pkg::GP_LO_W]);
      neg4  <= neg3;
      last4 <= last3;
    end
    if (!busy5) begin
      res5  <= prod[PW-1:mbsl_pkg::SCALE_SHIFT];
      neg5  <= neg4;
      last5 <= last4;
    end
  end

  assign out_valid = v5;
  assign res = res5;
  assign res_neg = neg5;
  assign res_last = last5;

endmodule

// ===== design/mbsl_limit.sv =====
`timescale 1ns / 1ps
module mbsl_limit #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int LIMIT_TABLE_DEPTH = 256
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [SAMPLE_WIDTH+3:0]      res,
  input  logic                         neg,
  input  logic                         last,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [SAMPLE_WIDTH:0] left_out,
  output logic signed [SAMPLE_WIDTH:0] right_out,
  output logic                         frame_last_out
);

  localparam int FRAC = SAMPLE_WIDTH - 1;
  localparam int RES_W = SAMPLE_WIDTH + 4;
  localparam int TERM_W = SAMPLE_WIDTH;
  localparam int IDX_W = (LIMIT_TABLE_DEPTH > 1) ? $clog2(LIMIT_TABLE_DEPTH) : 1;
  localparam int DEP_W = $clog2(LIMIT_TABLE_DEPTH + 1);
  localparam int IP_W = RES_W + DEP_W;
  localparam longint unsigned THR =
    (longint'(mbsl_pkg::THR_NUM) * (64'd1 << FRAC) + longint'(mbsl_pkg::THR_DEN / 2))
    / longint'(mbsl_pkg::THR_DEN);
  localparam longint unsigned QUARTER = (64'd1 << FRAC) / 4;
  localparam longint unsigned ONE = 64'd1 << 30;
  localparam logic [RES_W-1:0] THR_R = RES_W'(THR);
  localparam logic [TERM_W-1:0] THR_T = TERM_W'(THR);

  // tanh(4*i/DEPTH)/4 per entry, from exp(-8i/DEPTH) by series and four squarings
  logic [TERM_W-1:0] tab [LIMIT_TABLE_DEPTH];

  genvar i;
  for (i = 0; i < LIMIT_TABLE_DEPTH; i++) begin : g_tab
    localparam longint unsigned U = (64'(i) << 30) / (2 * LIMIT_TABLE_DEPTH);
    localparam longint unsigned T1 = ((ONE * U) >> 30) / 1;
    localparam longint unsigned T2 = ((T1 * U) >> 30) / 2;
    localparam longint unsigned T3 = ((T2 * U) >> 30) / 3;
    localparam longint unsigned T4 = ((T3 * U) >> 30) / 4;
    localparam longint unsigned T5 = ((T4 * U) >> 30) / 5;
    localparam longint unsigned T6 = ((T5 * U) >> 30) / 6;
    localparam longint unsigned T7 = ((T6 * U) >> 30) / 7;
    localparam longint unsigned T8 = ((T7 * U) >> 30) / 8;
    localparam longint unsigned T9 = ((T8 * U) >> 30) / 9;
    localparam longint unsigned T10 = ((T9 * U) >> 30) / 10;
    localparam longint unsigned T11 = ((T10 * U) >> 30) / 11;
    localparam longint unsigned T12 = ((T11 * U) >> 30) / 12;
    localparam longint ACC = longint'(ONE) - longint'(T1) + longint'(T2) - longint'(T3)
                           + longint'(T4) - longint'(T5) + longint'(T6) - longint'(T7)
                           + longint'(T8) - longint'(T9) + longint'(T10) - longint'(T11)
                           + longint'(T12);
    localparam longint unsigned E0 = (ACC < 0) ? 64'd0 : 64'(ACC);
    localparam longint unsigned E1 = (E0 * E0) >> 30;
    localparam longint unsigned E2 = (E1 * E1) >> 30;
    localparam longint unsigned E3 = (E2 * E2) >> 30;
    localparam longint unsigned E4 = (E3 * E3) >> 30;
    localparam longint unsigned EC = (E4 > ONE) ? ONE : E4;
    localparam longint unsigned NUM = (ONE - EC) << FRAC;
    localparam longint unsigned DEN = 4 * (ONE + EC);
    localparam longint unsigned ENTRY = (NUM + DEN / 2) / DEN;
    assign tab[i] = TERM_W'(ENTRY);
  end

  logic               v6;
  logic [RES_W-1:0]   over6;
  logic [TERM_W-1:0]  pass6;
  logic               thru6;
  logic               neg6;
  logic               last6;
  logic               v7;
  logic [IDX_W-1:0]   idx7;
  logic               sat7;
  logic [TERM_W-1:0]  pass7;
  logic               thru7;
  logic               neg7;
  logic               last7;
  logic               v8;
  logic [TERM_W-1:0]  term8;
  logic [TERM_W-1:0]  pass8;
  logic               thru8;
  logic               neg8;
  logic               last8;
  logic               v9;
  logic signed [SAMPLE_WIDTH:0] val9;
  logic               last9;
  logic               busy6;
  logic               busy7;
  logic               busy8;
  logic               busy9;
  logic [IP_W-1:0]    iprod;
  logic [IP_W-1:0]    ifull;
  logic [TERM_W-1:0]  mag8;
  logic [SAMPLE_WIDTH:0] mag8x;

  assign busy9 = v9 && out_stall;
  assign busy8 = v8 && busy9;
  assign busy7 = v7 && busy8;
  assign busy6 = v6 && busy7;
  assign in_stall = busy6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
      v7 <= 1'b0;
      v8 <= 1'b0;
      v9 <= 1'b0;
    end else begin
      if (!busy6) v6 <= in_valid;
      if (!busy7) v7 <= v6;
      if (!busy8) v8 <= v7;
      if (!busy9) v9 <= v8;
    end
  end

  assign iprod = IP_W'(over6) * IP_W'(LIMIT_TABLE_DEPTH);
  assign ifull = iprod >> FRAC;
  assign mag8 = thru8 ? pass8 : (THR_T + term8);
  assign mag8x = {1'b0, mag8};

  always_ff @(posedge clk) begin
    if (!busy6) begin
      thru6 <= (res <= THR_R);
      over6 <= res - THR_R;
      pass6 <= res[TERM_W-1:0];
      neg6  <= neg;
      last6 <= last;
    end
    if (!busy7) begin
      sat7  <= (ifull >= IP_W'(LIMIT_TABLE_DEPTH));
      idx7  <= ifull[IDX_W-1:0];
      pass7 <= pass6;
      thru7 <= thru6;
      neg7  <= neg6;
      last7 <= last6;
    end
    if (!busy8) begin
      term8 <= sat7 ? TERM_W'(QUARTER) : tab[idx7];
      pass8 <= pass7;
      thru8 <= thru7;
      neg8  <= neg7;
      last8 <= last7;
    end
    if (!busy9) begin
      val9  <= neg8 ? $signed(~mag8x + (SAMPLE_WIDTH + 1)'(1)) : $signed(mag8x);
      last9 <= last8;
    end
  end

  assign out_valid = v9;
  assign left_out = val9;
  assign right_out = val9;
  assign frame_last_out = last9;

endmodule

// ===== design/mix_bus_soft_limiter_top.sv =====
// Mix bus with soft limiter.
// Input channel: in_valid / in_stall with four signed channel samples and a
// frame-end flag; one frame per beat. Output channel: out_valid / out_stall
// with the limited bus sample on left_out and right_out (identical values)
// and the frame-end flag copied to frame_last_out.
// master_gain is written through cfg_we / cfg_data (unsigned Q2.14); write it
// only while no frame is in flight. Reset sets the gain to 1.0.
// Each accepted beat passes through nine registered stages (sum, magnitude,
// two partial multiplies, round, limiter compare, table index, table read,
// output register). Throughput: one beat per cycle while the receiver does
// not stall; each stage holds one beat.
// When the receiver stalls, the output beat holds and the stages behind it
// keep filling empty slots; in_stall rises only once every stage is full.
// Reset is synchronous: it empties the pipeline and in_stall stays high
// while rst is high.
`timescale 1ns / 1ps
module mix_bus_soft_limiter_top #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int LIMIT_TABLE_DEPTH = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic        [15:0]             cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_ch1,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_ch2,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_ch3,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_ch4,
  input  logic                           frame_last_in,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SAMPLE_WIDTH:0]   left_out,
  output logic signed [SAMPLE_WIDTH:0]   right_out,
  output logic                           frame_last_out
);

  logic                    sum_stall;
  logic                    sum_valid;
  logic                    scl_stall;
  logic [SAMPLE_WIDTH+1:0] sum_mag;
  logic                    sum_neg;
  logic                    sum_last;
  logic                    scl_valid;
  logic                    lim_stall;
  logic [SAMPLE_WIDTH+3:0] scl_res;
  logic                    scl_neg;
  logic                    scl_last;

  assign in_stall = rst || sum_stall;

  mbsl_sum #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_sum (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (sum_stall),
    .sample_ch1   (sample_ch1),
    .sample_ch2   (sample_ch2),
    .sample_ch3   (sample_ch3),
    .sample_ch4   (sample_ch4),
    .frame_last_in(frame_last_in),
    .out_valid    (sum_valid),
    .out_stall    (scl_stall),
    .mag          (sum_mag),
    .neg          (sum_neg),
    .last         (sum_last)
  );

  mbsl_scale #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_scale (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_valid (sum_valid),
    .in_stall (scl_stall),
    .mag      (sum_mag),
    .neg      (sum_neg),
    .last     (sum_last),
    .out_valid(scl_valid),
    .out_stall(lim_stall),
    .res      (scl_res),
    .res_neg  (scl_neg),
    .res_last (scl_last)
  );

  mbsl_limit #(
    .SAMPLE_WIDTH     (SAMPLE_WIDTH),
    .LIMIT_TABLE_DEPTH(LIMIT_TABLE_DEPTH)
  ) u_limit (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (scl_valid),
    .in_stall      (lim_stall),
    .res           (scl_res),
    .neg           (scl_neg),
    .last          (scl_last),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .left_out      (left_out),
    .right_out     (right_out),
    .frame_last_out(frame_last_out)
  );

endmodule

// ===== design/mbsl_check.sv =====
`timescale 1ns / 1ps
module mbsl_check #(
  parameter int SAMPLE_WIDTH = 16
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic signed [SAMPLE_WIDTH:0]   left_out,
  input logic signed [SAMPLE_WIDTH:0]   right_out,
  input logic                           frame_last_out
);

  localparam int FRAC = SAMPLE_WIDTH - 1;
  localparam longint THR =
    (longint'(mbsl_pkg::THR_NUM) * (64'sd1 <<< FRAC) + longint'(mbsl_pkg::THR_DEN / 2))
    / longint'(mbsl_pkg::THR_DEN);
  localparam longint LIM = THR + ((64'sd1 <<< FRAC) / 4);

  // a held output beat keeps its sample and flag
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(left_out) && $stable(frame_last_out))
    else $error("output beat changed while stalled");

  a_lr_equal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> left_out == right_out)
    else $error("left and right differ");

  a_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (longint'(left_out) <= LIM) && (longint'(left_out) >= -LIM))
    else $error("limited sample exceeds ceiling");

  // outside reset, back-pressure only comes from a full pipeline behind a stalled output
  a_stall_src: assert property (@(posedge clk)
    in_stall |-> rst || (out_valid && out_stall))
    else $error("input stalled without output stall");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind mix_bus_soft_limiter_top mbsl_check #(
  .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_mbsl_check (
  .clk           (clk),
  .rst           (rst),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .left_out      (left_out),
  .right_out     (right_out),
  .frame_last_out(frame_last_out)
);
